@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/izn_pkg.sv @@
package izn_pkg;

    // Sizes of the datapath
    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int FRAC_BITS   = 16;
    localparam int ITERATIONS  = 10;
    localparam int CELL_STAGES = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_DATA_W  = 8;

    typedef logic signed [WORD_W-1:0] word_t;

    // Quadratic coefficient and starting point of every neuron
    localparam word_t QUAD_COEF = word_t'(2621);
    localparam word_t V_INIT    = word_t'(-64'sd70 <<< FRAC_BITS);
    localparam word_t U_INIT    = word_t'(-64'sd14 <<< FRAC_BITS);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STEP_V       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_U       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_COEF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_TERM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECOV_SENS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THRESH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_VOLT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RECOV_JUMP   = 3'd7;

    // Neuron parameters seen by every cell
    typedef struct packed {
        logic [HALF_W-1:0] step_v;
        logic [HALF_W-1:0] step_u;
        word_t             lin_coef;
        word_t             bias_term;
        word_t             recov_sens;
        word_t             spike_thresh;
        word_t             reset_volt;
        word_t             recov_jump;
    } cfg_t;

    // Fixed-point product: full product, floor shift, wrap to one word
    function automatic word_t fx_mul(input word_t a, input word_t b);
        logic signed [2*WORD_W-1:0] prod;
        prod = a * b;
        return prod[FRAC_BITS+WORD_W-1:FRAC_BITS];
    endfunction

endpackage

@@ rtl/izn_cell.sv @@
`include "assert_macros.svh"

// One Euler step of the neuron, five register stages deep.
module izn_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  izn_pkg::cfg_t cfg,
    input  logic          vld_in,
    input  izn_pkg::word_t v_in,
    input  izn_pkg::word_t u_in,
    input  izn_pkg::word_t cur_in,
    output logic          vld_out,
    output izn_pkg::word_t v_out,
    output izn_pkg::word_t u_out,
    output izn_pkg::word_t cur_out,
    output logic          fired_out
);
    import izn_pkg::*;

    logic [CELL_STAGES-1:0] vld_reg;

    // stage 1: products of v
    word_t v1_reg, u1_reg, cur1_reg, qv1_reg, lv1_reg, bv1_reg;
    // stage 2: quadratic term, partial drive, recovery difference
    word_t v2_reg, u2_reg, cur2_reg, qd2_reg, part2_reg, du2_reg;
    // stage 3: full drive, recovery increment
    word_t v3_reg, u3_reg, cur3_reg, drive3_reg, mu3_reg;
    // stage 4: voltage increment, new recovery
    word_t v4_reg, cur4_reg, dv4_reg, un4_reg;
    // stage 5: new state after threshold
    word_t v5_reg, u5_reg, cur5_reg;
    logic  fired5_reg;

    word_t v_next, u_next, vn;
    logic  fire;

    // threshold check and spike reset
    always_comb
    begin
        vn     = v4_reg + dv4_reg;
        fire   = (vn > cfg.spike_thresh);
        v_next = fire ? cfg.reset_volt : vn;
        u_next = fire ? (un4_reg + cfg.recov_jump) : un4_reg;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[CELL_STAGES-2:0], vld_in};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_reg     <= v_in;
            u1_reg     <= u_in;
            cur1_reg   <= cur_in;
            qv1_reg    <= fx_mul(QUAD_COEF, v_in);
            lv1_reg    <= fx_mul(cfg.lin_coef, v_in);
            bv1_reg    <= fx_mul(cfg.recov_sens, v_in);

            v2_reg     <= v1_reg;
            u2_reg     <= u1_reg;
            cur2_reg   <= cur1_reg;
            qd2_reg    <= fx_mul(qv1_reg, v1_reg);
            part2_reg  <= lv1_reg + cfg.bias_term - u1_reg + cur1_reg;
            du2_reg    <= bv1_reg - u1_reg;

            v3_reg     <= v2_reg;
            u3_reg     <= u2_reg;
            cur3_reg   <= cur2_reg;
            drive3_reg <= qd2_reg + part2_reg;
            mu3_reg    <= fx_mul(word_t'({{HALF_W{1'b0}}, cfg.step_u}), du2_reg);

            v4_reg     <= v3_reg;
            cur4_reg   <= cur3_reg;
            dv4_reg    <= fx_mul(word_t'({{HALF_W{1'b0}}, cfg.step_v}), drive3_reg);
            un4_reg    <= u3_reg + mu3_reg;

            v5_reg     <= v_next;
            u5_reg     <= u_next;
            cur5_reg   <= cur4_reg;
            fired5_reg <= fire;
        end
    end

    assign vld_out   = vld_reg[CELL_STAGES-1];
    assign v_out     = v5_reg;
    assign u_out     = u5_reg;
    assign cur_out   = cur5_reg;
    assign fired_out = fired5_reg;

    `ASSERT_NEXT(a_enter, clk, rst_n, adv && vld_in, vld_reg[0], "cell: item lost on entry")
    `ASSERT_NEXT(a_freeze, clk, rst_n, !adv, $stable(vld_reg), "cell: moved while stalled")
    `ASSERT_NEXT(a_spike_reset, clk, rst_n, adv && fire,
        fired5_reg && (v5_reg == $past(cfg.reset_volt)), "cell: spike did not reset v")

endmodule

@@ rtl/izhikevich_neuron_spike_step_core.sv @@
// Channel  | Signals                          | Payload
// ---------+----------------------------------+-----------------------------
// s_axis   | s_axis_tvalid/tready/tdata[31:0] | current_in (signed Q16.16)
// m_axis   | m_axis_tvalid/tready/tdata[7:0]  | spike in bit 0, rest zero
// cfg      | cfg_we, cfg_index, cfg_data      | eight neuron registers
//
// Takes one current per cycle while m_axis is not blocked; a chain of
// ITERATIONS step cells, each five stages deep, feeds the output register.
// Reset loads the register defaults and clears all valid bits.
// A result held on m_axis with tready low freezes the whole chain and
// drops s_axis_tready in the same cycle.
`include "assert_macros.svh"

module izhikevich_neuron_spike_step_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [izn_pkg::WORD_W-1:0]   s_axis_tdata,   // [31:0] current_in
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [izn_pkg::OUT_DATA_W-1:0] m_axis_tdata, // [0] spike, [7:1] zero
    input  logic                         cfg_we,
    input  logic [izn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [izn_pkg::WORD_W-1:0]   cfg_data
);
    import izn_pkg::*;

    cfg_t  cfg_reg;
    logic  adv;
    logic  out_vld_reg;
    logic  out_spike_reg;

    logic  vld_link [ITERATIONS+1];
    word_t v_link   [ITERATIONS+1];
    word_t u_link   [ITERATIONS+1];
    word_t cur_link [ITERATIONS+1];
    logic  fired_link [ITERATIONS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_v       <= HALF_W'(65);
            cfg_reg.step_u       <= HALF_W'(1);
            cfg_reg.lin_coef     <= word_t'(327680);
            cfg_reg.bias_term    <= word_t'(9175040);
            cfg_reg.recov_sens   <= word_t'(13107);
            cfg_reg.spike_thresh <= word_t'(1966080);
            cfg_reg.reset_volt   <= word_t'(-4259840);
            cfg_reg.recov_jump   <= word_t'(524288);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_V:       cfg_reg.step_v       <= cfg_data[HALF_W-1:0];
                REG_STEP_U:       cfg_reg.step_u       <= cfg_data[HALF_W-1:0];
                REG_LIN_COEF:     cfg_reg.lin_coef     <= cfg_data;
                REG_BIAS_TERM:    cfg_reg.bias_term    <= cfg_data;
                REG_RECOV_SENS:   cfg_reg.recov_sens   <= cfg_data;
                REG_SPIKE_THRESH: cfg_reg.spike_thresh <= cfg_data;
                REG_RESET_VOLT:   cfg_reg.reset_volt   <= cfg_data;
                REG_RECOV_JUMP:   cfg_reg.recov_jump   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // chain moves whenever the output register can take a result
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // head of the chain: fresh neuron state plus the current
    assign vld_link[0] = s_axis_tvalid;
    assign v_link[0]   = V_INIT;
    assign u_link[0]   = U_INIT;
    assign cur_link[0] = s_axis_tdata;

    // row of step cells
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        izn_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .cfg       (cfg_reg),
            .vld_in    (vld_link[i]),
            .v_in      (v_link[i]),
            .u_in      (u_link[i]),
            .cur_in    (cur_link[i]),
            .vld_out   (vld_link[i+1]),
            .v_out     (v_link[i+1]),
            .u_out     (u_link[i+1]),
            .cur_out   (cur_link[i+1]),
            .fired_out (fired_link[i])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= vld_link[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_spike_reg <= fired_link[ITERATIONS-1];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_spike_reg};

    `ASSERT_IMPLY(a_stall_back, clk, rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "core: input taken while output blocked")
    `ASSERT_NEXT(a_result_held, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "core: blocked result changed")
    `ASSERT_NEXT(a_load_out, clk, rst_n, adv && vld_link[ITERATIONS], m_axis_tvalid,
        "core: finished item not registered")

endmodule

@@ sim/izn_spike_checker.sv @@
`timescale 1ns / 1ps

module izn_spike_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [izn_pkg::WORD_W-1:0]     s_axis_tdata,   // [31:0] current_in
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [izn_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [0] spike, [7:1] zero
    input  logic                           cfg_we,
    input  logic [izn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [izn_pkg::WORD_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending
);

    import izn_pkg::*;

    // Register values after reset
    localparam logic [HALF_W-1:0] STEP_V_RST       = 16'd65;
    localparam logic [HALF_W-1:0] STEP_U_RST       = 16'd1;
    localparam word_t             LIN_COEF_RST     = 32'sd327680;
    localparam word_t             BIAS_TERM_RST    = 32'sd9175040;
    localparam word_t             RECOV_SENS_RST   = 32'sd13107;
    localparam word_t             SPIKE_THRESH_RST = 32'sd1966080;
    localparam word_t             RESET_VOLT_RST   = -32'sd4259840;
    localparam word_t             RECOV_JUMP_RST   = 32'sd524288;

    cfg_t neuron_params;
    logic spike_queue [$];
    logic want_spike;

    // Q16.16 product: exact 64-bit product, arithmetic shift, keep the low word
    function automatic word_t fixed_product(input word_t a, input word_t b);
        logic signed [2*WORD_W-1:0] wide_a;
        logic signed [2*WORD_W-1:0] wide_b;
        logic signed [2*WORD_W-1:0] full;
        wide_a = a;
        wide_b = b;
        full = wide_a * wide_b;
        return word_t'(full >>> FRAC_BITS);
    endfunction

    // Run the Euler steps of one neuron and return the last step's spike flag
    function automatic logic neuron_fires(input word_t current, input cfg_t p);
        word_t volt;
        word_t recov;
        word_t quad;
        word_t drive;
        word_t volt_next;
        word_t recov_next;
        word_t scale_v;
        word_t scale_u;
        logic  fired;
        volt    = V_INIT;
        recov   = U_INIT;
        fired   = 1'b0;
        scale_v = word_t'({16'd0, p.step_v});
        scale_u = word_t'({16'd0, p.step_u});
        for (int n = 0; n < ITERATIONS; n++)
        begin
            quad       = fixed_product(fixed_product(QUAD_COEF, volt), volt);
            drive      = quad + fixed_product(p.lin_coef, volt) + p.bias_term - recov + current;
            volt_next  = volt + fixed_product(scale_v, drive);
            recov_next = recov + fixed_product(scale_u,
                                               fixed_product(p.recov_sens, volt) - recov);
            if (volt_next > p.spike_thresh)
            begin
                fired = 1'b1;
                volt  = p.reset_volt;
                recov = recov_next + p.recov_jump;
            end
            else
            begin
                fired = 1'b0;
                volt  = volt_next;
                recov = recov_next;
            end
        end
        return fired;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neuron_params.step_v       = STEP_V_RST;
            neuron_params.step_u       = STEP_U_RST;
            neuron_params.lin_coef     = LIN_COEF_RST;
            neuron_params.bias_term    = BIAS_TERM_RST;
            neuron_params.recov_sens   = RECOV_SENS_RST;
            neuron_params.spike_thresh = SPIKE_THRESH_RST;
            neuron_params.reset_volt   = RESET_VOLT_RST;
            neuron_params.recov_jump   = RECOV_JUMP_RST;
            spike_queue.delete();
            pending = 0;
        end
        else
        begin
            // shadow copy of the register file; step scales keep 16 bits
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_V:       neuron_params.step_v       = cfg_data[HALF_W-1:0];
                    REG_STEP_U:       neuron_params.step_u       = cfg_data[HALF_W-1:0];
                    REG_LIN_COEF:     neuron_params.lin_coef     = cfg_data;
                    REG_BIAS_TERM:    neuron_params.bias_term    = cfg_data;
                    REG_RECOV_SENS:   neuron_params.recov_sens   = cfg_data;
                    REG_SPIKE_THRESH: neuron_params.spike_thresh = cfg_data;
                    REG_RESET_VOLT:   neuron_params.reset_volt   = cfg_data;
                    REG_RECOV_JUMP:   neuron_params.recov_jump   = cfg_data;
                    default:          ;
                endcase
            end

            // result transfer: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (spike_queue.size() == 0)
                begin
                    $error("spike: expected none, actual %0b", m_axis_tdata[0]);
                    errors++;
                end
                else
                begin
                    want_spike = spike_queue.pop_front();
                    if (m_axis_tdata[0] !== want_spike)
                    begin
                        $error("spike: expected %0b, actual %0b", want_spike, m_axis_tdata[0]);
                        errors++;
                    end
                end
                if (m_axis_tdata[OUT_DATA_W-1:1] !== '0)
                begin
                    $error("pad: expected 0, actual %0h", m_axis_tdata[OUT_DATA_W-1:1]);
                    errors++;
                end
            end

            // current transfer: predict its spike
            if (s_axis_tvalid && s_axis_tready)
                spike_queue.push_back(neuron_fires(word_t'(s_axis_tdata), neuron_params));

            pending = spike_queue.size();
        end
    end

endmodule

@@ sim/tb_izhikevich_neuron_spike_step_core.sv @@
`timescale 1ns / 1ps

module tb_izhikevich_neuron_spike_step_core;

    import izn_pkg::*;

    localparam int LATENCY      = CELL_STAGES * ITERATIONS + 1;
    localparam int PHASE_ITEMS  = 175;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_PROBES   = 22;

    // Raw register words as written on the config port
    typedef struct packed {
        logic [31:0] step_v;
        logic [31:0] step_u;
        logic [31:0] lin_coef;
        logic [31:0] bias_term;
        logic [31:0] recov_sens;
        logic [31:0] spike_thresh;
        logic [31:0] reset_volt;
        logic [31:0] recov_jump;
    } reg_image_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [WORD_W-1:0]       s_axis_tdata  = '0;   // [31:0] current_in
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;         // [0] spike, [7:1] zero
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [WORD_W-1:0]       cfg_data      = '0;

    int errors;
    int pending;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_cnt      = 0;
    int cycle_count   = 0;

    // Directed currents: zero, extremes, bit patterns and a sweep of drives
    logic [31:0] probe_currents [NUM_PROBES] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0005_0000,
        32'h000A_0000, 32'h0014_0000, 32'h0032_0000, 32'h0064_0000,
        32'h03E8_0000, 32'h2710_0000, 32'h4E20_0000, 32'h7530_0000,
        32'hFC18_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001,
        32'h7FFF_0000, 32'h1000_0000
    };

    always #2 clk = ~clk;

    izhikevich_neuron_spike_step_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    izn_spike_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random backpressure, plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= 0;
            hold_seen     <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen     <= hold_req;
            hold_cnt      <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt      <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct <= sink_pct;
    endtask

    // One current transfer, preceded by random idle cycles
    task automatic send_current(input logic [31:0] current);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= current;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Stop offering and wait until every spike has come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_params(input reg_image_t img);
        write_reg(REG_STEP_V, img.step_v);
        write_reg(REG_STEP_U, img.step_u);
        write_reg(REG_LIN_COEF, img.lin_coef);
        write_reg(REG_BIAS_TERM, img.bias_term);
        write_reg(REG_RECOV_SENS, img.recov_sens);
        write_reg(REG_SPIKE_THRESH, img.spike_thresh);
        write_reg(REG_RESET_VOLT, img.reset_volt);
        write_reg(REG_RECOV_JUMP, img.recov_jump);
        cfg_we <= 1'b0;
    endtask

    // Register settings per phase: plausible neurons, extremes, random words
    function automatic reg_image_t phase_image(input int phase);
        reg_image_t img;
        case (phase)
            1, 4:
            begin
                img.step_v       = {16'($urandom()), 16'($urandom_range(1, 4000))};
                img.step_u       = $urandom_range(0, 500);
                img.lin_coef     = $urandom_range(3 << 16, 7 << 16);
                img.bias_term    = $urandom_range(100, 180) << 16;
                img.recov_sens   = $urandom_range(0, 32'h8000);
                img.spike_thresh = $urandom_range(20, 40) << 16;
                img.reset_volt   = 32'd0 - ($urandom_range(50, 70) << 16);
                img.recov_jump   = $urandom_range(0, 10) << 16;
            end
            2:
            begin
                img.step_v       = 32'hFFFF_FFFF;
                img.step_u       = 32'hFFFF_FFFF;
                img.lin_coef     = 32'h7FFF_FFFF;
                img.bias_term    = 32'h7FFF_FFFF;
                img.recov_sens   = 32'h7FFF_FFFF;
                img.spike_thresh = 32'h7FFF_FFFF;
                img.reset_volt   = 32'h7FFF_FFFF;
                img.recov_jump   = 32'h7FFF_FFFF;
            end
            3, 6:
            begin
                img.step_v       = $urandom();
                img.step_u       = $urandom();
                img.lin_coef     = $urandom();
                img.bias_term    = $urandom();
                img.recov_sens   = $urandom();
                img.spike_thresh = $urandom();
                img.reset_volt   = $urandom();
                img.recov_jump   = $urandom();
            end
            5:
            begin
                img.step_v       = 32'h0000_0000;
                img.step_u       = 32'h0000_0000;
                img.lin_coef     = 32'h8000_0000;
                img.bias_term    = 32'h8000_0000;
                img.recov_sens   = 32'h8000_0000;
                img.spike_thresh = 32'h8000_0000;
                img.reset_volt   = 32'h8000_0000;
                img.recov_jump   = 32'h8000_0000;
            end
            7:
                img = '0;
            default:
            begin
                // back to the power-up values
                img.step_v       = 32'd65;
                img.step_u       = 32'd1;
                img.lin_coef     = 32'd327680;
                img.bias_term    = 32'd9175040;
                img.recov_sens   = 32'd13107;
                img.spike_thresh = 32'd1966080;
                img.reset_volt   = 32'hFFBF_0000;
                img.recov_jump   = 32'd524288;
            end
        endcase
        return img;
    endfunction

    // Mostly full-range words, with typical drives and extremes mixed in
    function automatic logic [31:0] pick_current();
        logic [31:0] value;
        case ($urandom_range(5))
            0, 1, 2: value = $urandom();
            3:       value = 32'($urandom_range(0, 128 << 16)) - 32'(64 << 16);
            4:       value = $urandom_range(0, 32'h7FFF_FFFF);
            default:
            begin
                case ($urandom_range(3))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    2:       value = 32'h0000_0000;
                    default: value = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return value;
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed currents with the reset settings
        set_idling(27, 68);
        for (int i = 0; i < NUM_PROBES; i++)
            send_current(probe_currents[i]);

        // random phases, each with its own register settings
        for (int phase = 1; phase <= 8; phase++)
        begin
            drain();
            load_params(phase_image(phase));
            if (phase <= 3)
                set_idling(27, 68);
            else if (phase <= 6)
                set_idling(68, 27);
            else
                set_idling(0, 0);
            // long receiver hold so the chain fills and stalls its input
            if (phase == 8)
                hold_req <= hold_req + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_current(pick_current());
        end

        drain();
        repeat (2 * LATENCY) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
